FILE: hdl/esp_pkg.sv
// Package for the escape-stuffing packetizer.
// Holds the packet size, the action codes and the item structs of both channels.
// Used by escape_stuffing_packetizer_unit; depends on nothing.
package esp_pkg;

    // Largest packet in bytes (legal range 2 to 63).
    localparam int PACKET_BYTES = 32;

    // Width of the fill counter and of the reported length.
    localparam int LEN_W = 6;

    // Action codes of an input item.
    localparam logic ACT_DATA = 1'b0;
    localparam logic ACT_END  = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_present;
        logic             packet_end;
        logic [LEN_W-1:0] packet_length;
        logic             run_last;
    } out_item_t;

endpackage

FILE: hdl/escape_stuffing_packetizer_unit.sv
// Top level of the escape-stuffing packetizer.
// Depends on esp_pkg for the packet size, action codes and item structs.
//
// Usage: message bytes and end-of-message items enter on the in_ channel
// (valid/ready). Result items leave on the out_ channel (valid/ready), one
// per cycle: a plain byte gives one result, a byte equal to the escape
// character gives two (the doubled pair) or three (a close marker first when
// the pair does not fit in the open packet), and end of message gives one.
// The escape character is written through cfg_we/cfg_data while idle.
// An item's first result passes the work register and then the output
// register before it is valid on out_. The single output register sets a
// throughput of one result item per cycle, so a plain byte or end of message
// is accepted every cycle and an escaped byte holds off the next item until
// its last result moves on. An accepted item sits in a work register while
// its results are produced; when the receiver stalls, the output register
// holds its result and the work register holds the item, and in_ready drops
// until the last result of the held item moves on. Reset empties both
// registers, clears the fill count and sets the escape character to zero.
module escape_stuffing_packetizer_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  esp_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output esp_pkg::out_item_t out_data,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_data
);

    localparam int CNT_W = esp_pkg::LEN_W + 1;
    localparam logic [CNT_W-1:0] PKT_LIMIT = CNT_W'(esp_pkg::PACKET_BYTES);

    logic [7:0]                escape_reg;
    logic [esp_pkg::LEN_W-1:0] fill_reg, fill_next;
    logic                      work_valid_reg;
    esp_pkg::in_item_t         work_item_reg;
    logic                      pair_second_reg, pair_second_next;
    logic                      out_valid_reg;
    esp_pkg::out_item_t        out_data_reg, res;

    logic             advance;
    logic             in_fire;
    logic             is_escape;
    logic [CNT_W-1:0] fill_plus1;
    logic [CNT_W-1:0] fill_plus2;

    assign advance    = work_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !work_valid_reg || (advance && res.run_last);
    assign in_fire    = in_valid && in_ready;
    assign is_escape  = (work_item_reg.in_byte == escape_reg);
    assign fill_plus1 = {1'b0, fill_reg} + CNT_W'(1);
    assign fill_plus2 = {1'b0, fill_reg} + CNT_W'(2);

    // One result of the held item per step; the second byte of an escape
    // pair is produced in the step after the first.
    always_comb
    begin
        res              = '0;
        fill_next        = fill_reg;
        pair_second_next = 1'b0;
        if (work_item_reg.action == esp_pkg::ACT_END)
        begin
            res.out_byte      = escape_reg;
            res.byte_present  = 1'b1;
            res.packet_end    = 1'b1;
            res.packet_length = fill_plus1[esp_pkg::LEN_W-1:0];
            res.run_last      = 1'b1;
            fill_next         = '0;
        end
        else if (pair_second_reg)
        begin
            res.out_byte     = escape_reg;
            res.byte_present = 1'b1;
            res.run_last     = 1'b1;
            if (fill_plus1 >= PKT_LIMIT)
            begin
                res.packet_end    = 1'b1;
                res.packet_length = fill_plus1[esp_pkg::LEN_W-1:0];
                fill_next         = '0;
            end
            else
            begin
                fill_next = fill_plus1[esp_pkg::LEN_W-1:0];
            end
        end
        else if (is_escape)
        begin
            if (fill_plus2 > PKT_LIMIT)
            begin
                // Pair does not fit: close the packet with a marker and retry
                // the pair on an empty packet in the next step.
                res.packet_end    = 1'b1;
                res.packet_length = fill_reg;
                fill_next         = '0;
            end
            else
            begin
                res.out_byte     = work_item_reg.in_byte;
                res.byte_present = 1'b1;
                fill_next        = fill_plus1[esp_pkg::LEN_W-1:0];
                pair_second_next = 1'b1;
            end
        end
        else
        begin
            res.out_byte     = work_item_reg.in_byte;
            res.byte_present = 1'b1;
            res.run_last     = 1'b1;
            if (fill_plus1 >= PKT_LIMIT)
            begin
                res.packet_end    = 1'b1;
                res.packet_length = fill_plus1[esp_pkg::LEN_W-1:0];
                fill_next         = '0;
            end
            else
            begin
                fill_next = fill_plus1[esp_pkg::LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg      <= '0;
            fill_reg        <= '0;
            work_valid_reg  <= 1'b0;
            pair_second_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                escape_reg <= cfg_data;
            end
            if (advance)
            begin
                fill_reg        <= fill_next;
                pair_second_reg <= pair_second_next;
            end
            if (in_fire)
            begin
                work_valid_reg <= 1'b1;
            end
            else if (advance && res.run_last)
            begin
                work_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            work_item_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The open packet never holds a full packet's worth of bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, fill_reg} < PKT_LIMIT)
    else $error("fill count reached the packet size");

    // A close marker always closes a packet and is never an item's last result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.byte_present
        |-> out_data_reg.packet_end && !out_data_reg.run_last)
    else $error("malformed close marker");

    // Length is reported only on a closing result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.packet_end |-> out_data_reg.packet_length == '0)
    else $error("length on a non-closing result");

    // The second byte of a pair only ever follows a held item.
    assert property (@(posedge clk) disable iff (!rst_n)
        pair_second_reg |-> work_valid_reg)
    else $error("pair pending without a held item");

    // A new item is never taken while the held one still owes results.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && work_valid_reg |-> advance && res.run_last)
    else $error("item accepted over an unfinished one");

endmodule
